FILE: rtl/core/lscc_pkg.sv
// package: shared constants, types and tables of the line sensor calibrate and centroid block
`timescale 1ns / 1ps
`default_nettype none
package lscc_pkg;

   localparam int SENSOR_COUNT = 16;
   localparam int SAMPLE_BITS  = 12;
   localparam int IDX_W        = 4;
   localparam int POS_W        = 16;
   localparam int SCALE_W      = 15;
   localparam int CNT_W        = 5;
   localparam int CNT_TOP      = 31;
   localparam int WACC_W       = 30;
   localparam int LACC_W       = 17;
   localparam int WEIGHT_STEP  = 1000;
   localparam int WEIGHT_W     = $clog2(WEIGHT_STEP * SENSOR_COUNT + 1);
   localparam int PMAX         = (WEIGHT_STEP * (SENSOR_COUNT + 1)) / 2;
   localparam int PMAX2        = 2 * PMAX;
   localparam int NUM_W        = $clog2(PMAX2 + 1);
   localparam int MUL_W        = 30;
   localparam int PROD_W       = 2 * MUL_W;
   localparam int RECIP3_SHIFT = 17;
   localparam int RECIP3       = ((2 ** RECIP3_SHIFT) + 2) / 3;
   // reciprocal of the half span, exact for every scaled centroid
   localparam int     RECIP_PMAX_SHIFT = 43;
   localparam longint RECIP_PMAX       =
      ((longint'(1) << RECIP_PMAX_SHIFT) + longint'(PMAX) - 1) / longint'(PMAX);
   localparam int DIV_N_W      = WACC_W;
   localparam int DIV_D_W      = LACC_W;
   localparam int DIV_CNT_W    = $clog2(DIV_N_W + 1);
   localparam int CSR_IDX_W    = 2;
   localparam int CSR_DATA_W   = 15;

   typedef logic [SAMPLE_BITS-1:0] sample_type;
   typedef logic [IDX_W-1:0]       idx_type;
   typedef logic [IDX_W:0]         idx_ext_type;
   typedef logic [CNT_W-1:0]       cnt_type;
   typedef logic [CNT_W:0]         cnt_ext_type;
   typedef logic [SCALE_W-1:0]     scale_type;
   typedef logic [WEIGHT_W-1:0]    weight_type;

   typedef enum logic [CSR_IDX_W-1:0] {
      REG_LEVEL_LOW      = 2'd0,
      REG_LEVEL_HIGH     = 2'd1,
      REG_POSITION_SCALE = 2'd2,
      REG_MIN_SPREAD     = 2'd3
   } csr_index_type;

   typedef struct packed {
      sample_type max_val;
      sample_type min_val;
      sample_type thr_val;
   } cal_rd_type;

   typedef struct packed {
      logic       en;
      idx_type    idx;
      sample_type max_val;
      sample_type min_val;
      sample_type thr_val;
   } cal_wr_type;

   typedef struct packed {
      logic               start;
      logic [DIV_N_W-1:0] dividend;
      logic [DIV_D_W-1:0] divisor;
   } div_req_type;

   typedef struct packed {
      logic               done;
      logic [DIV_N_W-1:0] quotient;
   } div_rsp_type;

   // weight of a sensor in the centroid sum
   function automatic weight_type weight_of(input idx_type idx);
      weight_of = weight_type'((int'(idx) + 1) * WEIGHT_STEP);
   endfunction

endpackage
`default_nettype wire

FILE: rtl/core/lscc_intf.sv
// interfaces: sample request, result and register write channels
`timescale 1ns / 1ps
`default_nettype none
interface lscc_req_if import lscc_pkg::*;;
   logic                    valid;
   logic                    ready;
   logic                    req_type;
   idx_type                 sensor_index;
   sample_type              raw_sample;
   logic signed [POS_W-1:0] previous_position;

   modport source (output valid, output req_type, output sensor_index, output raw_sample,
                   output previous_position, input ready);
   modport sink   (input valid, input req_type, input sensor_index, input raw_sample,
                   input previous_position, output ready);
endinterface

interface lscc_rsp_if import lscc_pkg::*;;
   logic                    valid;
   logic                    ready;
   logic                    result_kind;
   logic signed [POS_W-1:0] position;
   logic                    line_found;
   logic                    calibration_ok;

   modport source (output valid, output result_kind, output position, output line_found,
                   output calibration_ok, input ready);
   modport sink   (input valid, input result_kind, input position, input line_found,
                   input calibration_ok, output ready);
endinterface

interface lscc_csr_if import lscc_pkg::*;;
   logic                  valid;
   logic                  ready;
   logic [CSR_IDX_W-1:0]  reg_index;
   logic [CSR_DATA_W-1:0] wr_data;

   modport source (output valid, output reg_index, output wr_data, input ready);
   modport sink   (input valid, input reg_index, input wr_data, output ready);
endinterface
`default_nettype wire

FILE: rtl/core/lscc_div.sv
// restoring divider, one quotient bit per cycle
`timescale 1ns / 1ps
`default_nettype none
module lscc_div import lscc_pkg::*; (
   input  logic        clock,
   input  logic        reset,
   input  div_req_type div_req,
   output div_rsp_type div_rsp
);

   logic                 busy_ff, busy_in;
   logic                 done_ff, done_in;
   logic [DIV_CNT_W-1:0] cnt_ff, cnt_in;
   logic [DIV_D_W-1:0]   rem_ff, rem_in;
   logic [DIV_N_W-1:0]   quo_ff, quo_in;
   logic [DIV_D_W-1:0]   divisor_ff, divisor_in;
   logic [DIV_D_W:0]     rem_sh;
   logic [DIV_D_W:0]     trial;

   always_comb begin
      busy_in    = busy_ff;
      done_in    = 1'b0;
      cnt_in     = cnt_ff;
      rem_in     = rem_ff;
      quo_in     = quo_ff;
      divisor_in = divisor_ff;
      rem_sh     = {rem_ff, quo_ff[DIV_N_W-1]};
      trial      = rem_sh - {1'b0, divisor_ff};
      if (div_req.start) begin
         busy_in    = 1'b1;
         cnt_in     = DIV_CNT_W'(DIV_N_W);
         rem_in     = '0;
         quo_in     = div_req.dividend;
         divisor_in = div_req.divisor;
      end else if (busy_ff) begin
         if (!trial[DIV_D_W]) begin
            rem_in = trial[DIV_D_W-1:0];
            quo_in = {quo_ff[DIV_N_W-2:0], 1'b1};
         end else begin
            rem_in = rem_sh[DIV_D_W-1:0];
            quo_in = {quo_ff[DIV_N_W-2:0], 1'b0};
         end
         cnt_in = cnt_ff - 1'b1;
         if (cnt_ff == DIV_CNT_W'(1)) begin
            busy_in = 1'b0;
            done_in = 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
         cnt_ff  <= '0;
      end else begin
         busy_ff <= busy_in;
         done_ff <= done_in;
         cnt_ff  <= cnt_in;
      end
      rem_ff     <= rem_in;
      quo_ff     <= quo_in;
      divisor_ff <= divisor_in;
   end

   assign div_rsp.done     = done_ff;
   assign div_rsp.quotient = quo_ff;

endmodule
`default_nettype wire

FILE: rtl/core/lscc_cal_store.sv
// per-sensor minimum, maximum and threshold storage
`timescale 1ns / 1ps
`default_nettype none
module lscc_cal_store import lscc_pkg::*; (
   input  logic       clock,
   input  logic       reset,
   input  idx_type    rd_idx,
   input  cal_wr_type wr,
   output cal_rd_type rd
);

   sample_type max_ff [SENSOR_COUNT];
   sample_type min_ff [SENSOR_COUNT];
   sample_type thr_ff [SENSOR_COUNT];
   cal_rd_type rd_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         for (int i = 0; i < SENSOR_COUNT; i++) begin
            max_ff[i] <= '0;
            min_ff[i] <= '1;
            thr_ff[i] <= '0;
         end
      end else if (wr.en) begin
         max_ff[wr.idx] <= wr.max_val;
         min_ff[wr.idx] <= wr.min_val;
         thr_ff[wr.idx] <= wr.thr_val;
      end
      rd_ff.max_val <= max_ff[rd_idx];
      rd_ff.min_val <= min_ff[rd_idx];
      rd_ff.thr_val <= thr_ff[rd_idx];
   end

   assign rd = rd_ff;

endmodule
`default_nettype wire

FILE: rtl/core/line_sensor_calibrate_and_centroid.sv
// top level: calibration and weighted-centroid line position sequencer
//
//  channel  dir  beat carries                                            handshake
//  req_bus  in   req_type, sensor_index, raw_sample, previous_position   valid/ready
//  rsp_bus  out  result_kind, position, line_found, calibration_ok       valid/ready
//  csr_bus  in   reg_index, wr_data                                      valid/ready
//
// a sample beat holds req_bus off through store read, update, shared multiply and write back
// (tracking: level select, accumulate); the last tracking sample may run the 30-step divider
// for the centroid quotient; scaling by the half span is a shared reciprocal multiply.
// reset is synchronous; stores come out of reset with their reset contents at once.
// a finished result sits in an output register, so a stalled rsp_bus only holds the
// block when the next result is ready.
`timescale 1ns / 1ps
`default_nettype none
module line_sensor_calibrate_and_centroid import lscc_pkg::*; (
   input  logic       clock,
   input  logic       reset,
   lscc_req_if.sink   req_bus,
   lscc_rsp_if.source rsp_bus,
   lscc_csr_if.sink   csr_bus
);

   typedef enum logic [3:0] {
      ST_IDLE,
      ST_READ,
      ST_CAL_UPD,
      ST_CAL_MUL,
      ST_CAL_WR,
      ST_TRK_LVL,
      ST_TRK_MUL,
      ST_TRK_ACC,
      ST_TRK_END,
      ST_DIV1,
      ST_MAP,
      ST_MAP_MUL,
      ST_RECIP_MUL,
      ST_MAP_END,
      ST_FINISH
   } state_type;

   state_type               state_ff, state_in;

   sample_type              level_low_ff, level_low_in;
   sample_type              level_high_ff, level_high_in;
   scale_type               scale_ff, scale_in;
   sample_type              min_spread_ff, min_spread_in;

   logic                    kind_ff, kind_in;
   idx_type                 idx_ff, idx_in;
   sample_type              raw_ff, raw_in;
   logic                    prev_neg_ff, prev_neg_in;

   sample_type              mx_ff, mx_in;
   sample_type              mn_ff, mn_in;
   sample_type              spread_ff, spread_in;
   sample_type              lvl_ff, lvl_in;
   logic [PROD_W-1:0]       prod_ff;
   logic [DIV_N_W-1:0]      num_ff, num_in;

   logic [WACC_W-1:0]       wacc_ff, wacc_in;
   logic [LACC_W-1:0]       lacc_ff, lacc_in;
   cnt_type                 dc_ff, dc_in;
   cnt_type                 spok_ff, spok_in;

   div_req_type             div_req_ff, div_req_in;
   div_rsp_type             div_rsp;

   logic                    res_kind_ff, res_kind_in;
   logic signed [POS_W-1:0] res_pos_ff, res_pos_in;
   logic                    res_found_ff, res_found_in;
   logic                    res_ok_ff, res_ok_in;

   logic                    rsp_valid_ff, rsp_valid_in;
   logic                    out_kind_ff, out_kind_in;
   logic signed [POS_W-1:0] out_pos_ff, out_pos_in;
   logic                    out_found_ff, out_found_in;
   logic                    out_ok_ff, out_ok_in;

   cal_rd_type              cal_rd;
   cal_wr_type              cal_wr;

   logic [MUL_W-1:0]        mul_a;
   logic [MUL_W-1:0]        mul_b;
   logic                    last;
   logic                    high;
   logic                    found;
   sample_type              mx_new;
   sample_type              mn_new;
   logic [SAMPLE_BITS:0]    third;
   logic [NUM_W+1:0]        pos_diff;
   logic [POS_W-1:0]        scale_ext;

   assign req_bus.ready = (state_ff == ST_IDLE);
   assign csr_bus.ready = 1'b1;
   assign last          = (idx_ff == idx_type'(SENSOR_COUNT - 1));
   assign scale_ext     = POS_W'(scale_ff);

   lscc_cal_store u_store (
      .clock  (clock),
      .reset  (reset),
      .rd_idx (idx_ff),
      .wr     (cal_wr),
      .rd     (cal_rd)
   );

   lscc_div u_div (
      .clock   (clock),
      .reset   (reset),
      .div_req (div_req_ff),
      .div_rsp (div_rsp)
   );

   // shared multiplier operand select
   always_comb begin
      case (state_ff)
         ST_CAL_MUL: begin
            mul_a = MUL_W'({spread_ff, 1'b0});
            mul_b = MUL_W'(RECIP3);
         end
         ST_TRK_MUL: begin
            mul_a = MUL_W'(weight_of(idx_ff));
            mul_b = MUL_W'(lvl_ff);
         end
         ST_MAP_MUL: begin
            mul_a = MUL_W'(num_ff[NUM_W-1:0]);
            mul_b = MUL_W'(scale_ff);
         end
         ST_RECIP_MUL: begin
            mul_a = prod_ff[MUL_W-1:0];
            mul_b = MUL_W'(RECIP_PMAX);
         end
         default: begin
            mul_a = '0;
            mul_b = '0;
         end
      endcase
   end

   always_comb begin
      state_in      = state_ff;
      level_low_in  = level_low_ff;
      level_high_in = level_high_ff;
      scale_in      = scale_ff;
      min_spread_in = min_spread_ff;
      kind_in       = kind_ff;
      idx_in        = idx_ff;
      raw_in        = raw_ff;
      prev_neg_in   = prev_neg_ff;
      mx_in         = mx_ff;
      mn_in         = mn_ff;
      spread_in     = spread_ff;
      lvl_in        = lvl_ff;
      num_in        = num_ff;
      wacc_in       = wacc_ff;
      lacc_in       = lacc_ff;
      dc_in         = dc_ff;
      spok_in       = spok_ff;
      div_req_in    = div_req_ff;
      div_req_in.start = 1'b0;
      res_kind_in   = res_kind_ff;
      res_pos_in    = res_pos_ff;
      res_found_in  = res_found_ff;
      res_ok_in     = res_ok_ff;
      rsp_valid_in  = rsp_valid_ff;
      out_kind_in   = out_kind_ff;
      out_pos_in    = out_pos_ff;
      out_found_in  = out_found_ff;
      out_ok_in     = out_ok_ff;
      cal_wr        = '0;
      high          = 1'b0;
      found         = 1'b0;
      mx_new        = '0;
      mn_new        = '0;
      third         = prod_ff[RECIP3_SHIFT +: SAMPLE_BITS+1];
      pos_diff      = (NUM_W+2)'(prod_ff[RECIP_PMAX_SHIFT +: NUM_W+2]) -
                      (NUM_W+2)'(scale_ff);

      if (rsp_valid_ff && rsp_bus.ready) begin
         rsp_valid_in = 1'b0;
      end

      if (csr_bus.valid) begin
         case (csr_index_type'(csr_bus.reg_index))
            REG_LEVEL_LOW:      level_low_in  = csr_bus.wr_data[SAMPLE_BITS-1:0];
            REG_LEVEL_HIGH:     level_high_in = csr_bus.wr_data[SAMPLE_BITS-1:0];
            REG_POSITION_SCALE: scale_in      = csr_bus.wr_data[SCALE_W-1:0];
            REG_MIN_SPREAD:     min_spread_in = csr_bus.wr_data[SAMPLE_BITS-1:0];
            default:            scale_in      = scale_ff;
         endcase
      end

      case (state_ff)
         ST_IDLE: begin
            if (req_bus.valid) begin
               kind_in     = req_bus.req_type;
               idx_in      = req_bus.sensor_index;
               raw_in      = req_bus.raw_sample;
               prev_neg_in = req_bus.previous_position[POS_W-1];
               if ({1'b0, req_bus.sensor_index} < idx_ext_type'(SENSOR_COUNT)) begin
                  state_in = ST_READ;
               end
            end
         end
         ST_READ: begin
            state_in = kind_ff ? ST_TRK_LVL : ST_CAL_UPD;
         end
         ST_CAL_UPD: begin
            mx_new    = (raw_ff > cal_rd.max_val) ? raw_ff : cal_rd.max_val;
            mn_new    = (raw_ff < cal_rd.min_val) ? raw_ff : cal_rd.min_val;
            mx_in     = mx_new;
            mn_in     = mn_new;
            spread_in = (mx_new >= mn_new) ? (mx_new - mn_new) : (mn_new - mx_new);
            state_in  = ST_CAL_MUL;
         end
         ST_CAL_MUL: begin
            if (spread_ff >= min_spread_ff && spok_ff < cnt_type'(CNT_TOP)) begin
               spok_in = spok_ff + 1'b1;
            end
            state_in = ST_CAL_WR;
         end
         ST_CAL_WR: begin
            cal_wr.en      = 1'b1;
            cal_wr.idx     = idx_ff;
            cal_wr.max_val = mx_ff;
            cal_wr.min_val = mn_ff;
            cal_wr.thr_val = (mx_ff >= mn_ff) ? sample_type'(mn_ff + third[SAMPLE_BITS-1:0])
                                               : mn_ff;
            if (last) begin
               res_kind_in  = 1'b0;
               res_pos_in   = '0;
               res_found_in = 1'b0;
               res_ok_in    = ({1'b0, spok_ff} == cnt_ext_type'(SENSOR_COUNT));
               spok_in      = '0;
               state_in     = ST_FINISH;
            end else begin
               state_in = ST_IDLE;
            end
         end
         ST_TRK_LVL: begin
            high   = (raw_ff >= cal_rd.thr_val);
            lvl_in = high ? level_high_ff : level_low_ff;
            if (high && dc_ff < cnt_type'(CNT_TOP)) begin
               dc_in = dc_ff + 1'b1;
            end
            state_in = ST_TRK_MUL;
         end
         ST_TRK_MUL: begin
            state_in = ST_TRK_ACC;
         end
         ST_TRK_ACC: begin
            wacc_in  = wacc_ff + prod_ff[WACC_W-1:0];
            lacc_in  = lacc_ff + LACC_W'(lvl_ff);
            state_in = last ? ST_TRK_END : ST_IDLE;
         end
         ST_TRK_END: begin
            found        = (dc_ff != '0) && ({1'b0, dc_ff} < cnt_ext_type'(SENSOR_COUNT));
            res_kind_in  = 1'b1;
            res_found_in = found;
            res_ok_in    = 1'b0;
            wacc_in      = '0;
            lacc_in      = '0;
            dc_in        = '0;
            if (!found) begin
               res_pos_in = prev_neg_ff ? $signed(POS_W'(0) - scale_ext) : $signed(scale_ext);
               state_in   = ST_FINISH;
            end else if (lacc_ff == '0) begin
               num_in   = DIV_N_W'(PMAX);
               state_in = ST_MAP;
            end else begin
               div_req_in.start    = 1'b1;
               div_req_in.dividend = wacc_ff;
               div_req_in.divisor  = lacc_ff;
               state_in            = ST_DIV1;
            end
         end
         ST_DIV1: begin
            if (div_rsp.done) begin
               num_in   = div_rsp.quotient;
               state_in = ST_MAP;
            end
         end
         ST_MAP: begin
            if (num_ff > DIV_N_W'(PMAX2)) begin
               res_pos_in = $signed(scale_ext);
               state_in   = ST_FINISH;
            end else begin
               state_in = ST_MAP_MUL;
            end
         end
         ST_MAP_MUL: begin
            state_in = ST_RECIP_MUL;
         end
         ST_RECIP_MUL: begin
            state_in = ST_MAP_END;
         end
         ST_MAP_END: begin
            res_pos_in = $signed(pos_diff[POS_W-1:0]);
            state_in   = ST_FINISH;
         end
         ST_FINISH: begin
            if (!rsp_valid_ff || rsp_bus.ready) begin
               rsp_valid_in = 1'b1;
               out_kind_in  = res_kind_ff;
               out_pos_in   = res_pos_ff;
               out_found_in = res_found_ff;
               out_ok_in    = res_ok_ff;
               state_in     = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff         <= ST_IDLE;
         level_low_ff     <= sample_type'(0);
         level_high_ff    <= sample_type'(4095);
         scale_ff         <= scale_type'(1000);
         min_spread_ff    <= sample_type'(1000);
         wacc_ff          <= '0;
         lacc_ff          <= '0;
         dc_ff            <= '0;
         spok_ff          <= '0;
         div_req_ff.start <= 1'b0;
         rsp_valid_ff     <= 1'b0;
      end else begin
         state_ff         <= state_in;
         level_low_ff     <= level_low_in;
         level_high_ff    <= level_high_in;
         scale_ff         <= scale_in;
         min_spread_ff    <= min_spread_in;
         wacc_ff          <= wacc_in;
         lacc_ff          <= lacc_in;
         dc_ff            <= dc_in;
         spok_ff          <= spok_in;
         div_req_ff.start <= div_req_in.start;
         rsp_valid_ff     <= rsp_valid_in;
      end
      div_req_ff.dividend <= div_req_in.dividend;
      div_req_ff.divisor  <= div_req_in.divisor;
      kind_ff      <= kind_in;
      idx_ff       <= idx_in;
      raw_ff       <= raw_in;
      prev_neg_ff  <= prev_neg_in;
      mx_ff        <= mx_in;
      mn_ff        <= mn_in;
      spread_ff    <= spread_in;
      lvl_ff       <= lvl_in;
      prod_ff      <= mul_a * mul_b;
      num_ff       <= num_in;
      res_kind_ff  <= res_kind_in;
      res_pos_ff   <= res_pos_in;
      res_found_ff <= res_found_in;
      res_ok_ff    <= res_ok_in;
      out_kind_ff  <= out_kind_in;
      out_pos_ff   <= out_pos_in;
      out_found_ff <= out_found_in;
      out_ok_ff    <= out_ok_in;
   end

   assign rsp_bus.valid          = rsp_valid_ff;
   assign rsp_bus.result_kind    = out_kind_ff;
   assign rsp_bus.position       = out_pos_ff;
   assign rsp_bus.line_found     = out_found_ff;
   assign rsp_bus.calibration_ok = out_ok_ff;

endmodule
`default_nettype wire

FILE: rtl/core/lscc_checker.sv
// port-level checker for the line sensor block, bound to the top level
`timescale 1ns / 1ps
`default_nettype none
module lscc_checker import lscc_pkg::*; (
   input logic                    clock,
   input logic                    reset,
   input logic                    req_valid,
   input logic                    req_ready,
   input logic                    rsp_valid,
   input logic                    rsp_ready,
   input logic                    rsp_kind,
   input logic signed [POS_W-1:0] rsp_position,
   input logic                    rsp_found,
   input logic                    rsp_ok,
   input logic                    csr_valid,
   input logic                    csr_ready
);

   // an accepted sample makes the block busy in the following cycle
   a_busy_after_accept: assert property (@(posedge clock) disable iff (reset)
      req_valid && req_ready |=> !req_ready)
      else $error("req_ready high right after an accepted beat");

   // a new result only shows up while a sample is in work
   a_result_from_work: assert property (@(posedge clock) disable iff (reset)
      $rose(rsp_valid) |-> $past(!req_ready))
      else $error("result appeared while the block was idle");

   // unused fields of each result kind read zero
   a_kind_fields: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> ((rsp_kind && !rsp_ok) ||
                     (!rsp_kind && rsp_position == '0 && !rsp_found)))
      else $error("result carries fields of the other kind");

   // stalled result beat holds
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> rsp_valid && $stable(rsp_position) &&
                                  $stable(rsp_kind) && $stable(rsp_found) && $stable(rsp_ok))
      else $error("stalled result beat changed");

   // register writes are never stalled
   a_csr_open: assert property (@(posedge clock) disable iff (reset)
      csr_valid |-> csr_ready)
      else $error("register write stalled");

endmodule

bind line_sensor_calibrate_and_centroid lscc_checker u_lscc_checker (
   .clock        (clock),
   .reset        (reset),
   .req_valid    (req_bus.valid),
   .req_ready    (req_bus.ready),
   .rsp_valid    (rsp_bus.valid),
   .rsp_ready    (rsp_bus.ready),
   .rsp_kind     (rsp_bus.result_kind),
   .rsp_position (rsp_bus.position),
   .rsp_found    (rsp_bus.line_found),
   .rsp_ok       (rsp_bus.calibration_ok),
   .csr_valid    (csr_bus.valid),
   .csr_ready    (csr_bus.ready)
);
`default_nettype wire
